// ===== hdl/utf8ss_pkg.sv =====
// Shared types and constants of the UTF-8 stream sanitizer.
`timescale 1ns / 1ps

package utf8ss_pkg;

    // Bytes of the replacement character U+FFFD
    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    // Smallest code point that each sequence length may encode
    localparam logic [20:0] CP_MIN_LEN2 = 21'h000080;
    localparam logic [20:0] CP_MIN_LEN3 = 21'h000800;
    localparam logic [20:0] CP_MIN_LEN4 = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW    = 21'h00D800;
    localparam logic [20:0] SURR_HIGH   = 21'h00DFFF;

    // Sequence lengths
    localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN_2    = 3'd2;
    localparam logic [2:0] SEQ_LEN_3    = 3'd3;
    localparam logic [2:0] SEQ_LEN_4    = 3'd4;

    // Index of a byte inside one replacement character
    localparam logic [1:0] REPL_POS0 = 2'd0;
    localparam logic [1:0] REPL_POS1 = 2'd1;
    localparam logic [1:0] REPL_POS2 = 2'd2;

    // Up to four symbols per input byte; a symbol is one literal byte or one replacement
    typedef struct packed {
        logic [3:0]      rep;
        logic [3:0][7:0] data;
        logic [2:0]      cnt;
        logic            last;
    } sym_list_t;

endpackage

// ===== hdl/utf8ss_decode.sv =====
// Sequence tracker: holds pending bytes and turns each byte into a symbol list.
`timescale 1ns / 1ps

module utf8ss_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output utf8ss_pkg::sym_list_t syms
);
    import utf8ss_pkg::*;

    logic [7:0] held_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] seq_len_reg;
    logic [2:0] seq_len_next;

    logic        hold_we;
    logic [1:0]  hold_idx;
    logic        is_cont;
    logic [2:0]  lead_len;
    logic        complete;
    logic [20:0] cp;
    logic        seq_ok;
    logic [2:0]  reps;
    logic        tail;
    logic        tail_rep;
    logic        literal;

    assign is_cont  = (in_byte[7:6] == 2'b10);
    assign complete = (({1'b0, held_count_reg} + 3'd1) >= seq_len_reg);

    always_comb
    begin
        if (in_byte[7:5] == 3'b110)
            lead_len = SEQ_LEN_2;
        else if (in_byte[7:4] == 4'b1110)
            lead_len = SEQ_LEN_3;
        else if (in_byte[7:3] == 5'b11110)
            lead_len = SEQ_LEN_4;
        else
            lead_len = SEQ_LEN_NONE;
    end

    // Code point of a sequence that this byte completes
    always_comb
    begin
        case (seq_len_reg)
            SEQ_LEN_2:
            begin
                cp     = {10'd0, held_reg[0][4:0], in_byte[5:0]};
                seq_ok = (cp >= CP_MIN_LEN2);
            end
            SEQ_LEN_3:
            begin
                cp     = {5'd0, held_reg[0][3:0], held_reg[1][5:0], in_byte[5:0]};
                seq_ok = (cp >= CP_MIN_LEN3) && !((cp >= SURR_LOW) && (cp <= SURR_HIGH));
            end
            default:
            begin
                cp     = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], in_byte[5:0]};
                seq_ok = (cp >= CP_MIN_LEN4) && (cp <= CP_MAX);
            end
        endcase
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        hold_we         = 1'b0;
        hold_idx        = held_count_reg;
        reps            = 3'd0;
        tail            = 1'b0;
        tail_rep        = 1'b0;
        literal         = 1'b0;
        syms.rep        = '0;
        syms.data       = {4{in_byte}};
        syms.cnt        = 3'd0;
        syms.last       = in_last;

        if ((held_count_reg != 2'd0) && is_cont)
        begin
            if (complete)
            begin
                held_count_next = 2'd0;
                seq_len_next    = SEQ_LEN_NONE;
                if (seq_ok)
                    literal = 1'b1;
                else
                    reps = {1'b0, held_count_reg} + 3'd1;
            end
            else
            begin
                hold_we         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
                if (in_last)
                begin
                    reps            = {1'b0, held_count_reg} + 3'd1;
                    held_count_next = 2'd0;
                    seq_len_next    = SEQ_LEN_NONE;
                end
            end
        end
        else
        begin
            // Flush a broken sequence, then treat this byte as a fresh start
            reps            = {1'b0, held_count_reg};
            held_count_next = 2'd0;
            seq_len_next    = SEQ_LEN_NONE;
            if (!in_byte[7])
            begin
                tail = 1'b1;
            end
            else if (lead_len != SEQ_LEN_NONE)
            begin
                hold_we  = 1'b1;
                hold_idx = 2'd0;
                if (in_last)
                begin
                    tail     = 1'b1;
                    tail_rep = 1'b1;
                end
                else
                begin
                    held_count_next = 2'd1;
                    seq_len_next    = lead_len;
                end
            end
            else
            begin
                tail     = 1'b1;
                tail_rep = 1'b1;
            end
        end

        if (literal)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (3'(i) < {1'b0, held_count_reg})
                    syms.data[i] = held_reg[i];
            end
            syms.cnt = {1'b0, held_count_reg} + 3'd1;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                syms.rep[i] = (3'(i) < reps) || ((3'(i) == reps) && tail_rep);
            syms.cnt = reps + {2'd0, tail};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= SEQ_LEN_NONE;
        end
        else if (fire)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hold_we)
            held_reg[hold_idx] <= in_byte;
    end

endmodule

// ===== hdl/utf8ss_emit.sv =====
// Output sequencer: plays one symbol list out as a byte stream.
`timescale 1ns / 1ps

module utf8ss_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  utf8ss_pkg::sym_list_t syms,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  from_replacement,
    output logic                  run_end,
    output logic                  stream_end
);
    import utf8ss_pkg::*;

    sym_list_t  list_reg;
    logic       busy_reg;
    logic       busy_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [1:0] sub_reg;
    logic [1:0] sub_next;

    logic cur_rep;
    logic final_byte;
    logic xfer;

    assign cur_rep    = list_reg.rep[idx_reg];
    assign final_byte = ({1'b0, idx_reg} == (list_reg.cnt - 3'd1))
                        && (!cur_rep || (sub_reg == REPL_POS2));
    assign xfer       = busy_reg && !out_stall;
    assign free       = !busy_reg || (xfer && final_byte);

    always_comb
    begin
        if (cur_rep)
        begin
            case (sub_reg)
                REPL_POS0: out_byte = REPL_BYTE0;
                REPL_POS1: out_byte = REPL_BYTE1;
                default:   out_byte = REPL_BYTE2;
            endcase
        end
        else
        begin
            out_byte = list_reg.data[idx_reg];
        end
    end

    assign out_valid        = busy_reg;
    assign from_replacement = cur_rep;
    assign run_end          = final_byte;
    assign stream_end       = final_byte && list_reg.last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        sub_next  = sub_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
            sub_next  = REPL_POS0;
        end
        else if (xfer)
        begin
            if (final_byte)
            begin
                busy_next = 1'b0;
            end
            else if (cur_rep && (sub_reg != REPL_POS2))
            begin
                sub_next = sub_reg + 2'd1;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
                sub_next = REPL_POS0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            sub_reg  <= REPL_POS0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            list_reg <= syms;
    end

endmodule

// ===== hdl/utf8_stream_sanitizer.sv =====
// Top level of the UTF-8 stream sanitizer.
// Takes one byte per transfer and gives the sanitized byte stream: well-formed
// UTF-8 passes unchanged, every bad byte becomes EF BF BD, and held bytes of a
// sequence are released once it completes, breaks or the stream ends. An
// accepted byte waits in the input register until the output sequencer is
// free, then is decoded against the held sequence into up to four symbols,
// which the output sequencer sends one byte per cycle while the receiver
// does not stall; bytes that give zero or one output sustain one transfer
// per cycle while the receiver does not stall. Input stall rises while a
// decoded byte waits for the output sequencer, which is still busy with a run
// that the receiver has not yet taken up to its final byte.
`timescale 1ns / 1ps

module utf8_stream_sanitizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       from_replacement,
    output logic       run_end,
    output logic       stream_end
);
    import utf8ss_pkg::*;

    logic       pend_reg;
    logic       pend_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic      emit_free;
    logic      fire;
    logic      accept;
    sym_list_t syms;

    assign fire     = pend_reg && emit_free;
    assign in_stall = pend_reg && !emit_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
            pend_next = 1'b1;
        else if (fire)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    utf8ss_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (byte_reg),
        .in_last (last_reg),
        .syms    (syms)
    );

    // Skip the load for a byte that is only held
    utf8ss_emit u_emit
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (fire && (syms.cnt != 3'd0)),
        .syms             (syms),
        .free             (emit_free),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_byte         (out_byte),
        .from_replacement (from_replacement),
        .run_end          (run_end),
        .stream_end       (stream_end)
    );

endmodule

// ===== hdl/utf8ss_checker.sv =====
// Port-level checks of the UTF-8 stream sanitizer, bound to the top level.
`timescale 1ns / 1ps

module utf8ss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       from_replacement,
    input logic       run_end,
    input logic       stream_end
);
    import utf8ss_pkg::*;

    // Hold a stalled output transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(from_replacement) && $stable(run_end) && $stable(stream_end))
        else $error("stalled output changed");

    a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_end)
        else $error("stream end without run end");

    a_repl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && from_replacement |->
            (out_byte == REPL_BYTE0) || (out_byte == REPL_BYTE1) || (out_byte == REPL_BYTE2))
        else $error("replacement byte out of EF BF BD");

    // Passed bytes are never bytes that cannot appear in valid UTF-8
    a_pass_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !from_replacement |->
            (out_byte < 8'hF5) && (out_byte != 8'hC0) && (out_byte != 8'hC1))
        else $error("invalid byte passed through");

    // Advance through a replacement in order
    a_repl_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && from_replacement && (out_byte == REPL_BYTE0) |=>
            out_valid && from_replacement && (out_byte == REPL_BYTE1))
        else $error("replacement sequence broken");

endmodule

bind utf8_stream_sanitizer utf8ss_checker u_chk (.*);

// ===== tb/utf8_stream_sanitizer_check.sv =====
// Checker for the UTF-8 stream sanitizer: predicts the output bytes and compares them.
`timescale 1ns / 1ps

module utf8_stream_sanitizer_check
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       from_replacement,
    input  logic       run_end,
    input  logic       stream_end,
    output int         fail_count,
    output int         pending
);
    import utf8ss_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       last_of_step;
        logic       last_of_stream;
    } text_byte_t;

    text_byte_t expected_bytes[$];
    text_byte_t step_bytes[$];

    // Pending multi-byte sequence
    logic [7:0] seq_bytes[3];
    int         seq_held;
    logic [2:0] seq_len;

    task automatic emit(input logic [7:0] data, input logic repl);
        step_bytes.insert(step_bytes.size(), '{data, repl, 1'b0, 1'b0});
    endtask

    task automatic emit_replacement(input int times);
        repeat (times)
        begin
            emit(REPL_BYTE0, 1'b1);
            emit(REPL_BYTE1, 1'b1);
            emit(REPL_BYTE2, 1'b1);
        end
    endtask

    task automatic drop_sequence();
        seq_held = 0;
        seq_len  = SEQ_LEN_NONE;
    endtask

    task automatic open_sequence(input logic [7:0] b);
        logic [2:0] len;
        len = SEQ_LEN_NONE;
        if (b[7:5] == 3'b110)
            len = SEQ_LEN_2;
        else if (b[7:4] == 4'b1110)
            len = SEQ_LEN_3;
        else if (b[7:3] == 5'b11110)
            len = SEQ_LEN_4;

        if (!b[7])
            emit(b, 1'b0);
        else if (len == SEQ_LEN_NONE)
            emit_replacement(1);
        else
        begin
            seq_bytes[0] = b;
            seq_held     = 1;
            seq_len      = len;
        end
    endtask

    // Decode the held sequence closed by tail and judge the code point
    function automatic logic code_point_ok(input logic [7:0] tail);
        logic [20:0] cp;
        logic [20:0] floor_cp;
        int          i;
        case (seq_len)
            SEQ_LEN_2:
            begin
                cp       = {16'd0, seq_bytes[0][4:0]};
                floor_cp = CP_MIN_LEN2;
            end
            SEQ_LEN_3:
            begin
                cp       = {17'd0, seq_bytes[0][3:0]};
                floor_cp = CP_MIN_LEN3;
            end
            default:
            begin
                cp       = {18'd0, seq_bytes[0][2:0]};
                floor_cp = CP_MIN_LEN4;
            end
        endcase
        for (i = 1; i < seq_held; i++)
            cp = {cp[14:0], seq_bytes[i][5:0]};
        cp = {cp[14:0], tail[5:0]};
        return cp >= floor_cp && cp <= CP_MAX && !(cp >= SURR_LOW && cp <= SURR_HIGH);
    endfunction

    task automatic predict_step(input logic [7:0] b, input logic last);
        text_byte_t final_byte;
        int         i;
        step_bytes.delete();
        if (seq_held != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                if (seq_held + 1 >= seq_len)
                begin
                    if (code_point_ok(b))
                    begin
                        for (i = 0; i < seq_held; i++)
                            emit(seq_bytes[i], 1'b0);
                        emit(b, 1'b0);
                    end
                    else
                        emit_replacement(seq_held + 1);
                    drop_sequence();
                end
                else
                begin
                    seq_bytes[seq_held] = b;
                    seq_held++;
                end
            end
            else
            begin
                // Break the sequence, then treat the byte as a fresh start
                emit_replacement(seq_held);
                drop_sequence();
                open_sequence(b);
            end
        end
        else
            open_sequence(b);

        if (last && seq_held != 0)
        begin
            emit_replacement(seq_held);
            drop_sequence();
        end

        if (step_bytes.size() > 0)
        begin
            final_byte = step_bytes.pop_back();
            final_byte.last_of_step   = 1'b1;
            final_byte.last_of_stream = last;
            step_bytes.insert(step_bytes.size(), final_byte);
        end
        foreach (step_bytes[j])
            expected_bytes.insert(expected_bytes.size(), step_bytes[j]);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_transfer();
        text_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            fail_count++;
            $error("out_byte: expected nothing, got %h", out_byte);
        end
        else
        begin
            want = expected_bytes.pop_front();
            compare_field("out_byte", want.data, out_byte);
            compare_field("from_replacement", 8'(want.repl), 8'(from_replacement));
            compare_field("run_end", 8'(want.last_of_step), 8'(run_end));
            compare_field("stream_end", 8'(want.last_of_stream), 8'(stream_end));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            drop_sequence();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_transfer();
            if (in_valid && !in_stall)
                predict_step(in_byte, in_last);
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== tb/utf8_stream_sanitizer_test.sv =====
// Testbench top of the UTF-8 stream sanitizer: drives byte streams and reports the verdict.
`timescale 1ns / 1ps

module utf8_stream_sanitizer_test;

    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 50000;
    localparam int TAIL_CYCLES = 20;

    // Opening streams, {in_last, in_byte}; the first entry sent is the top one
    localparam int OPENING_LEN = 27;
    localparam logic [OPENING_LEN-1:0][8:0] OPENING = {
        9'h000, 9'h07F,                 // ASCII extremes
        9'h080, 9'h0FF,                 // lone continuation, invalid lead
        9'h0C2, 9'h080,                 // smallest two-byte form
        9'h0C0, 9'h080,                 // overlong two-byte
        9'h0E0, 9'h080, 9'h080,         // overlong three-byte
        9'h0ED, 9'h0A0, 9'h080,         // surrogate
        9'h0F4, 9'h090, 9'h080, 9'h080, // above the code point range
        9'h0E2, 9'h082, 9'h041,         // sequence broken by ASCII
        9'h0F0, 9'h090, 9'h080, 9'h1C3, // broken by a lead that ends the stream
        9'h0E2, 9'h182                  // stream ends inside a sequence
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       from_replacement;
    logic       run_end;
    logic       stream_end;

    int fail_count;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_ask = 0;

    logic [7:0] text_q[$];

    utf8_stream_sanitizer dut (.*);

    utf8_stream_sanitizer_check checker_i (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        int n;
        in_valid <= 1'b0;
        @(posedge clk);
        n = 0;
        while (pending != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic int unsigned valid_code_point(input int len);
        case (len)
            1: return $urandom_range(0, 'h7F);
            2: return $urandom_range('h80, 'h7FF);
            3: return ($urandom_range(1) != 0) ? $urandom_range('h800, 'hD7FF)
                                                : $urandom_range('hE000, 'hFFFF);
            default: return $urandom_range('h10000, 'h10FFFF);
        endcase
    endfunction

    // Encode cp in len bytes whether or not it fits that form
    task automatic add_cp(input logic [20:0] cp, input int len);
        case (len)
            1: text_q.insert(text_q.size(), {1'b0, cp[6:0]});
            2:
            begin
                text_q.insert(text_q.size(), {3'b110, cp[10:6]});
                text_q.insert(text_q.size(), {2'b10, cp[5:0]});
            end
            3:
            begin
                text_q.insert(text_q.size(), {4'b1110, cp[15:12]});
                text_q.insert(text_q.size(), {2'b10, cp[11:6]});
                text_q.insert(text_q.size(), {2'b10, cp[5:0]});
            end
            default:
            begin
                text_q.insert(text_q.size(), {5'b11110, cp[20:18]});
                text_q.insert(text_q.size(), {2'b10, cp[17:12]});
                text_q.insert(text_q.size(), {2'b10, cp[11:6]});
                text_q.insert(text_q.size(), {2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_char();
        int pick;
        int len;
        pick = $urandom_range(99);
        len  = $urandom_range(1, 4);
        if (pick < 66)
            add_cp(21'(valid_code_point(len)), len);
        else if (pick < 72)
            text_q.insert(text_q.size(), 8'($urandom));
        else if (pick < 78)
        begin
            // Overlong: a code point that fits the next shorter form
            len = $urandom_range(2, 4);
            add_cp(21'(valid_code_point(len - 1)), len);
        end
        else if (pick < 83)
            add_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
        else if (pick < 88)
            add_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        else if (pick < 95)
        begin
            // Truncate a valid sequence so the next byte breaks it
            len = $urandom_range(2, 4);
            add_cp(21'(valid_code_point(len)), len);
            repeat ($urandom_range(1, len - 1))
                void'(text_q.pop_back());
        end
        else if (pick < 98)
            text_q.insert(text_q.size(), 8'($urandom_range('h80, 'hBF)));
        else
            text_q.insert(text_q.size(), 8'($urandom_range('hF8, 'hFF)));
    endtask

    task automatic run_streams(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 8))
                add_char();
            foreach (text_q[i])
                send_byte(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
        end
    endtask

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                repeat (LONG_HOLD)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int i;
        send_idle = 38;
        recv_idle = 88;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = OPENING_LEN - 1; i >= 0; i--)
            send_byte(OPENING[i][7:0], OPENING[i][8]);
        wait_drained();

        run_streams(45);
        send_idle = 88;
        recv_idle = 38;
        run_streams(45);

        // Hold the output while bytes keep coming so the block backs up
        send_idle = 0;
        recv_idle = 0;
        hold_ask <= hold_ask + 1;
        run_streams(40);

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (pending != 0)
            $error("%0d expected bytes never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== utf8_stream_sanitizer.f =====
hdl/utf8ss_pkg.sv
hdl/utf8ss_decode.sv
hdl/utf8ss_emit.sv
hdl/utf8_stream_sanitizer.sv
hdl/utf8ss_checker.sv
tb/utf8_stream_sanitizer_check.sv
tb/utf8_stream_sanitizer_test.sv
